### design/cmv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmv_pkg
// Shared types and constants for the centroid motion vote block.
// ----------------------------------------------------------------------------
package cmv_pkg;

    localparam int MAX_POINTS  = 65536;
    localparam int HISTORY_MAX = 16;
    localparam int COORD_W     = 18;
    localparam int CNT_W       = 17;
    localparam int SUM_W       = 34;
    localparam int DIFF_W      = 19;
    localparam int SQ_W        = 38;
    localparam int D2_W        = 40;
    localparam int TH_W        = 17;
    localparam int HLEN_W      = 5;
    localparam int HIDX_W      = 4;
    localparam int DIV_STEPS   = SUM_W;
    localparam int STEP_W      = 6;

    localparam logic [0:0] REG_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_HISTLEN   = 1'b1;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_DIST,
        ST_VOTE,
        ST_COUNT,
        ST_OUT
    } cmv_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_step;
        logic dist_calc;
        logic vote_push;
        logic count_step;
        logic count_clear;
        logic finish;
    } cmv_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic frame_end_seen;
        logic empty;
        logic first;
        logic div_done;
        logic count_done;
    } cmv_status_t;

endpackage
`default_nettype wire

### design/cmv_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmv_ctrl
// Sequencer: accepts point beats, then runs divide, distance, vote, count
// and result phases after a frame end; empty frames skip to count and the first frame skips the vote.
// ----------------------------------------------------------------------------
module cmv_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    input  wire                  out_ready,
    input  cmv_pkg::cmv_status_t status,
    output cmv_pkg::cmv_cmd_t    cmd,
    output logic                 in_ready,
    output logic                 out_valid
);

    cmv_pkg::cmv_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cmv_pkg::ST_ACCUM;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cmv_pkg::ST_ACCUM:
                if (in_valid && status.frame_end_seen)
                    state_next = cmv_pkg::ST_DIV_START;
            cmv_pkg::ST_DIV_START:
                state_next = status.empty ? cmv_pkg::ST_COUNT : cmv_pkg::ST_DIV_RUN;
            cmv_pkg::ST_DIV_RUN:
                if (status.div_done)
                    state_next = cmv_pkg::ST_DIST;
            cmv_pkg::ST_DIST:
                state_next = status.first ? cmv_pkg::ST_COUNT : cmv_pkg::ST_VOTE;
            cmv_pkg::ST_VOTE:
                state_next = cmv_pkg::ST_COUNT;
            cmv_pkg::ST_COUNT:
                if (status.count_done)
                    state_next = cmv_pkg::ST_OUT;
            cmv_pkg::ST_OUT:
                if (out_ready)
                    state_next = cmv_pkg::ST_ACCUM;
            default:
                state_next = cmv_pkg::ST_ACCUM;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd         = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        unique case (state_reg)
            cmv_pkg::ST_ACCUM:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            cmv_pkg::ST_DIV_START:
            begin
                cmd.div_start   = 1'b1;
                cmd.count_clear = 1'b1;
            end
            cmv_pkg::ST_DIV_RUN:
                cmd.div_step = 1'b1;
            cmv_pkg::ST_DIST:
                cmd.dist_calc = 1'b1;
            cmv_pkg::ST_VOTE:
                cmd.vote_push = 1'b1;
            cmv_pkg::ST_COUNT:
                cmd.count_step = 1'b1;
            cmv_pkg::ST_OUT:
            begin
                out_valid  = 1'b1;
                cmd.finish = out_ready;
            end
            default: ;
        endcase
    end

    // a result is shown only after a frame end beat was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> !$past(in_ready))
        else $error("result without preceding work");
    // input is never taken while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");
    // frame end moves the sequencer out of accumulate
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && status.frame_end_seen |=> !in_ready)
        else $error("frame end not closed");

endmodule
`default_nettype wire

### design/cmv_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmv_dp
// Datapath: axis sums, three-lane restoring divider, squared distance,
// vote history and serial vote count.
// ----------------------------------------------------------------------------
module cmv_dp (
    input  wire                               clk,
    input  wire                               rst_n,
    input  cmv_pkg::cmv_cmd_t                 cmd,
    output cmv_pkg::cmv_status_t              status,
    input  wire signed [cmv_pkg::COORD_W-1:0] point_x,
    input  wire signed [cmv_pkg::COORD_W-1:0] point_y,
    input  wire signed [cmv_pkg::COORD_W-1:0] point_z,
    input  wire                               point_valid,
    input  wire                               frame_end,
    input  wire        [cmv_pkg::TH_W-1:0]    threshold,
    input  wire        [cmv_pkg::HLEN_W-1:0]  hist_len,
    output logic                              moving_flag,
    output logic signed [cmv_pkg::COORD_W-1:0] centroid_x,
    output logic signed [cmv_pkg::COORD_W-1:0] centroid_y,
    output logic signed [cmv_pkg::COORD_W-1:0] centroid_z,
    output logic       [cmv_pkg::HLEN_W-1:0]  moving_votes,
    output logic       [cmv_pkg::HLEN_W-1:0]  history_fill,
    output logic                              frame_empty,
    output logic                              point_overflow
);
    localparam int SW = cmv_pkg::SUM_W;
    localparam int CW = cmv_pkg::CNT_W;
    localparam int HM = cmv_pkg::HISTORY_MAX;

    logic signed [SW-1:0] sum_reg [3];
    logic [CW-1:0]        cnt_reg;
    logic                 ovf_reg;
    logic                 first_reg;
    logic signed [cmv_pkg::COORD_W-1:0] prev_reg [3];
    logic signed [cmv_pkg::COORD_W-1:0] cen_reg [3];
    logic [HM-1:0]        hist_reg;
    logic [cmv_pkg::HLEN_W-1:0] held_reg;
    logic [SW-1:0]        quo_reg [3];
    logic [CW-1:0]        rem_reg [3];
    logic [2:0]           neg_reg;
    logic [cmv_pkg::STEP_W-1:0] step_reg;
    logic [cmv_pkg::SQ_W-1:0]   sq_reg [3];
    logic [cmv_pkg::HLEN_W-1:0] cidx_reg;
    logic [cmv_pkg::HLEN_W-1:0] votes_reg;
    logic                 moving_reg;
    logic                 empty_reg;

    // frame accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
                sum_reg[k] <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            for (int k = 0; k < 3; k++)
                sum_reg[k] <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.accept && point_valid)
        begin
            if (cnt_reg < CW'(cmv_pkg::MAX_POINTS))
            begin
                sum_reg[0] <= sum_reg[0] + SW'(point_x);
                sum_reg[1] <= sum_reg[1] + SW'(point_y);
                sum_reg[2] <= sum_reg[2] + SW'(point_z);
                cnt_reg    <= cnt_reg + 1'b1;
            end
            else
                ovf_reg <= 1'b1;
        end
    end

    // restoring divide of magnitudes, three lanes, one bit a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            for (int k = 0; k < 3; k++)
            begin
                neg_reg[k] <= sum_reg[k][SW-1];
                quo_reg[k] <= sum_reg[k][SW-1] ? SW'(-sum_reg[k]) : SW'(sum_reg[k]);
                rem_reg[k] <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic [CW:0] trial;
                trial = {rem_reg[k], quo_reg[k][SW-1]} - {1'b0, cnt_reg};
                if (!trial[CW])
                begin
                    rem_reg[k] <= trial[CW-1:0];
                    quo_reg[k] <= {quo_reg[k][SW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= {rem_reg[k][CW-2:0], quo_reg[k][SW-1]};
                    quo_reg[k] <= {quo_reg[k][SW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (cmd.div_start)
            step_reg <= '0;
        else if (cmd.div_step)
            step_reg <= step_reg + 1'b1;
    end

    logic signed [cmv_pkg::COORD_W-1:0] cen_now [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            cen_now[k] = neg_reg[k] ? -quo_reg[k][cmv_pkg::COORD_W-1:0]
                                    : quo_reg[k][cmv_pkg::COORD_W-1:0];
    end

    logic div_done;
    assign div_done = cmd.div_step && (step_reg == cmv_pkg::STEP_W'(cmv_pkg::DIV_STEPS - 1));

    // centroid, previous centroid and first-frame flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prev_reg[k] <= '0;
                cen_reg[k]  <= '0;
            end
            first_reg <= 1'b1;
        end
        else if (cmd.div_start)
        begin
            for (int k = 0; k < 3; k++)
                cen_reg[k] <= '0;
        end
        else if (cmd.dist_calc)
        begin
            for (int k = 0; k < 3; k++)
                cen_reg[k] <= cen_now[k];
            // first frame only seeds the previous centroid
            if (first_reg)
            begin
                for (int k = 0; k < 3; k++)
                    prev_reg[k] <= cen_now[k];
                first_reg <= 1'b0;
            end
        end
        else if (cmd.vote_push)
        begin
            for (int k = 0; k < 3; k++)
                prev_reg[k] <= cen_reg[k];
        end
    end

    // squared displacement per axis, one multiplier per lane
    always_ff @(posedge clk)
    begin
        if (cmd.dist_calc)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [cmv_pkg::DIFF_W-1:0] d;
                logic [cmv_pkg::DIFF_W-1:0] a;
                d = cmv_pkg::DIFF_W'(cen_now[k]) - cmv_pkg::DIFF_W'(prev_reg[k]);
                a = d[cmv_pkg::DIFF_W-1] ? cmv_pkg::DIFF_W'(-d) : cmv_pkg::DIFF_W'(d);
                sq_reg[k] <= a * a;
            end
        end
    end

    // vote push with oldest drop
    logic [cmv_pkg::D2_W-1:0] d2;
    logic [2*cmv_pkg::TH_W-1:0] th2;
    logic vote;
    logic [cmv_pkg::HLEN_W-1:0] eff_len, n_old, n_new;
    always_comb
    begin
        d2  = cmv_pkg::D2_W'(sq_reg[0]) + cmv_pkg::D2_W'(sq_reg[1])
            + cmv_pkg::D2_W'(sq_reg[2]);
        th2 = threshold * threshold;
        vote = d2 > cmv_pkg::D2_W'(th2);
        eff_len = (hist_len > cmv_pkg::HLEN_W'(HM)) ? cmv_pkg::HLEN_W'(HM) : hist_len;
        n_old = held_reg;
        n_new = n_old + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            held_reg <= '0;
        end
        else if (cmd.vote_push)
        begin
            logic [HM:0] tmp;
            tmp = {1'b0, hist_reg};
            tmp[n_old[cmv_pkg::HIDX_W:0]] = vote;
            if (n_new > eff_len)
            begin
                hist_reg <= tmp[HM:1];
                held_reg <= n_old;
            end
            else
            begin
                hist_reg <= tmp[HM-1:0];
                held_reg <= n_new;
            end
        end
    end

    // serial vote count over held entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cidx_reg  <= '0;
            votes_reg <= '0;
        end
        else if (cmd.count_clear)
        begin
            cidx_reg  <= '0;
            votes_reg <= '0;
        end
        else if (cmd.count_step && !status.count_done)
        begin
            votes_reg <= votes_reg + cmv_pkg::HLEN_W'(hist_reg[cidx_reg[cmv_pkg::HIDX_W-1:0]]);
            cidx_reg  <= cidx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moving_reg <= 1'b0;
            empty_reg  <= 1'b0;
        end
        else if (cmd.div_start)
        begin
            moving_reg <= 1'b0;
            empty_reg  <= (cnt_reg == '0);
        end
        else if (cmd.vote_push)
            moving_reg <= 1'b1;
    end

    always_comb
    begin
        status.frame_end_seen = frame_end;
        status.empty          = (cnt_reg == '0);
        status.first          = first_reg;
        status.div_done       = div_done;
        status.count_done     = (cidx_reg >= held_reg);
    end

    // result fields
    assign centroid_x     = cen_reg[0];
    assign centroid_y     = cen_reg[1];
    assign centroid_z     = cen_reg[2];
    assign moving_votes   = votes_reg;
    assign history_fill   = held_reg;
    assign frame_empty    = empty_reg;
    assign point_overflow = ovf_reg;
    assign moving_flag    = moving_reg && (votes_reg > (held_reg >> 1));

    // fill never exceeds the history depth
    assert property (@(posedge clk) disable iff (!rst_n) held_reg <= cmv_pkg::HLEN_W'(HM))
        else $error("history overfilled");
    // count never exceeds points bound
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(cmv_pkg::MAX_POINTS))
        else $error("point count out of bound");
    // a push changes the fill by at most one
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.vote_push |=> (held_reg == $past(held_reg) + 1'b1) || (held_reg == $past(held_reg))
                          || (held_reg == $past(held_reg) - 1'b1))
        else $error("fill jumped");

endmodule
`default_nettype wire

### design/centroid_motion_vote_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// centroid_motion_vote_core
// Lidar frame centroid and majority motion vote.
// ----------------------------------------------------------------------------
// Points are taken one beat per cycle while a frame accumulates. A beat with
// frame_end starts the back end: a setup state, a restoring divider (one
// quotient bit per cycle for all three axes), the squared distance, the vote
// push and the history count, then the result beat waits for out_ready.
// Empty frames skip the divider, distance and vote phases; the first frame
// skips the vote push.
module centroid_motion_vote_core (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire        [2:0]                  paddr,
    input  wire        [31:0]                 pwdata,
    output logic       [31:0]                 prdata,
    output logic                              pready,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire signed [cmv_pkg::COORD_W-1:0] point_x,
    input  wire signed [cmv_pkg::COORD_W-1:0] point_y,
    input  wire signed [cmv_pkg::COORD_W-1:0] point_z,
    input  wire                               point_valid,
    input  wire                               frame_end,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic                              moving_flag,
    output logic signed [cmv_pkg::COORD_W-1:0] centroid_x,
    output logic signed [cmv_pkg::COORD_W-1:0] centroid_y,
    output logic signed [cmv_pkg::COORD_W-1:0] centroid_z,
    output logic       [cmv_pkg::HLEN_W-1:0]  moving_votes,
    output logic       [cmv_pkg::HLEN_W-1:0]  history_fill,
    output logic                              frame_empty,
    output logic                              point_overflow
);

    logic [cmv_pkg::TH_W-1:0]   thresh_reg;
    logic [cmv_pkg::HLEN_W-1:0] hlen_reg;
    cmv_pkg::cmv_cmd_t    cmd;
    cmv_pkg::cmv_status_t status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= cmv_pkg::TH_W'(50);
            hlen_reg   <= cmv_pkg::HLEN_W'(5);
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == cmv_pkg::REG_THRESHOLD)
                thresh_reg <= pwdata[cmv_pkg::TH_W-1:0];
            else
                hlen_reg <= pwdata[cmv_pkg::HLEN_W-1:0];
        end
    end

    assign pready = 1'b1;
    always_comb
    begin
        if (paddr[2] == cmv_pkg::REG_HISTLEN)
            prdata = {27'd0, hlen_reg};
        else
            prdata = {15'd0, thresh_reg};
    end

    cmv_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .out_ready    (out_ready),
        .status       (status),
        .cmd          (cmd),
        .in_ready     (in_ready),
        .out_valid    (out_valid)
    );

    cmv_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_z        (point_z),
        .point_valid    (point_valid),
        .frame_end      (frame_end),
        .threshold      (thresh_reg),
        .hist_len       (hlen_reg),
        .moving_flag    (moving_flag),
        .centroid_x     (centroid_x),
        .centroid_y     (centroid_y),
        .centroid_z     (centroid_z),
        .moving_votes   (moving_votes),
        .history_fill   (history_fill),
        .frame_empty    (frame_empty),
        .point_overflow (point_overflow)
    );

endmodule
`default_nettype wire
